// ===== hdl/hm5s_pkg.sv =====
// ----------------------------------------------------------------------------
// hm5s_pkg
// Shared types, constants, the five-input median function and the index
// saturation function for the histogram median smoother.
// ----------------------------------------------------------------------------
package hm5s_pkg;

   localparam int MAX_BINS   = 256;
   localparam int COUNT_BITS = 20;
   localparam int INDEX_BITS = 8;
   localparam int SEEN_BITS  = 9;
   localparam int HIST_DEPTH = 4;
   localparam int MAX_RSP    = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);

   localparam logic [SEEN_BITS-1:0] SEEN_MAX = {SEEN_BITS{1'b1}};
   localparam int INDEX_CAP_INT = (MAX_BINS - 1 > 255) ? 255 : MAX_BINS - 1;
   localparam logic [SEEN_BITS-1:0] INDEX_CAP = SEEN_BITS'(INDEX_CAP_INT);

   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      count_type                          count;
      logic                               last;
      logic [HIST_DEPTH-1:0][COUNT_BITS-1:0] hist;
      logic [SEEN_BITS-1:0]               seen;
   } stage_type;

   typedef struct packed {
      count_type               smoothed_count;
      logic [INDEX_BITS-1:0]   bin_index;
      logic                    last_result;
      logic                    short_run;
   } result_type;

   typedef struct packed {
      logic [1:0]                 num;
      result_type [MAX_RSP-1:0]   entry;
   } push_type;

   function automatic count_type med5(count_type a, count_type b, count_type c,
                                      count_type d, count_type e);
      count_type v0, v1, v2, v3, v4, t;
      v0 = a; v1 = b; v2 = c; v3 = d; v4 = e;
      if (v0 > v3) begin t = v0; v0 = v3; v3 = t; end
      if (v1 > v4) begin t = v1; v1 = v4; v4 = t; end
      if (v0 > v2) begin t = v0; v0 = v2; v2 = t; end
      if (v1 > v3) begin t = v1; v1 = v3; v3 = t; end
      if (v0 > v1) begin t = v0; v0 = v1; v1 = t; end
      if (v2 > v4) begin t = v2; v2 = v4; v4 = t; end
      if (v1 > v2) begin t = v1; v1 = v2; v2 = t; end
      if (v3 > v4) begin t = v3; v3 = v4; v4 = t; end
      if (v2 > v3) begin t = v2; v2 = v3; v3 = t; end
      return v2;
   endfunction

   function automatic logic [INDEX_BITS-1:0] sat_index(logic [SEEN_BITS-1:0] idx);
      logic [SEEN_BITS-1:0] capped;
      capped = (idx > INDEX_CAP) ? INDEX_CAP : idx;
      return capped[INDEX_BITS-1:0];
   endfunction

endpackage

// ===== hdl/hm5s_window.sv =====
// ----------------------------------------------------------------------------
// hm5s_window
// Keeps the last four bins and the bin count of the current histogram, and
// registers each accepted item together with that history.
// ----------------------------------------------------------------------------
module hm5s_window (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [hm5s_pkg::COUNT_BITS-1:0] bin_count,
   input  logic                    last_bin,
   input  logic                    advance,
   output logic                    stage_valid,
   output hm5s_pkg::stage_type     stage
);
   import hm5s_pkg::*;

   logic [HIST_DEPTH-1:0][COUNT_BITS-1:0] hist_ff, hist_in;
   logic [SEEN_BITS-1:0] seen_ff, seen_in;
   logic                 valid_ff, valid_in;
   stage_type            stage_ff, stage_in;

   always_comb begin
      hist_in  = hist_ff;
      seen_in  = seen_ff;
      valid_in = valid_ff;
      stage_in = stage_ff;
      if (advance) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in       = 1'b1;
         stage_in.count = bin_count;
         stage_in.last  = last_bin;
         stage_in.hist  = hist_ff;
         stage_in.seen  = seen_ff;
         if (last_bin) begin
            hist_in = '0;
            seen_in = '0;
         end else begin
            hist_in = {hist_ff[HIST_DEPTH-2:0], bin_count};
            if (seen_ff != SEEN_MAX) begin
               seen_in = seen_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= '0;
         seen_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         hist_ff  <= hist_in;
         seen_ff  <= seen_in;
         valid_ff <= valid_in;
      end
      stage_ff <= stage_in;
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule

// ===== hdl/hm5s_median.sv =====
// ----------------------------------------------------------------------------
// hm5s_median
// Forms the mirrored five-bin windows of one registered item and sorts them
// into up to three results.
// ----------------------------------------------------------------------------
module hm5s_median (
   input  logic                 stage_valid,
   input  hm5s_pkg::stage_type  stage,
   output hm5s_pkg::push_type   push
);
   import hm5s_pkg::*;

   count_type c, h0, h1, h2, h3;
   count_type w0a, w0b, w0c, w0d, w0e;
   count_type m0, m1, m2;
   logic      tail_known;
   logic      is_three;
   logic      is_two;

   assign c  = stage.count;
   assign h0 = stage.hist[0];
   assign h1 = stage.hist[1];
   assign h2 = stage.hist[2];
   assign h3 = stage.hist[3];

   assign tail_known = (stage.seen >= SEEN_BITS'(4));
   assign is_three   = (stage.seen == SEEN_BITS'(3));
   assign is_two     = (stage.seen == SEEN_BITS'(2));

   always_comb begin
      if (tail_known) begin
         w0a = h3; w0b = h2; w0c = h1; w0d = h0; w0e = c;
      end else if (is_three) begin
         w0a = h1; w0b = h2; w0c = h1; w0d = h0; w0e = c;
      end else begin
         w0a = c;  w0b = h0; w0c = h1; w0d = h0; w0e = c;
      end
   end

   assign m0 = med5(w0a, w0b, w0c, w0d, w0e);
   assign m1 = med5(h2, h1, h0, c, h0);
   assign m2 = med5(h1, h0, c, h0, h1);

   always_comb begin
      push = '0;
      if (stage.last) begin
         if (!tail_known) begin
            push.num                        = 2'd1;
            push.entry[0].smoothed_count    = '0;
            push.entry[0].bin_index         = '0;
            push.entry[0].last_result       = 1'b1;
            push.entry[0].short_run         = 1'b1;
         end else begin
            push.num                        = 2'd3;
            push.entry[0].smoothed_count    = m0;
            push.entry[0].bin_index         = sat_index(stage.seen - SEEN_BITS'(2));
            push.entry[1].smoothed_count    = m1;
            push.entry[1].bin_index         = sat_index(stage.seen - SEEN_BITS'(1));
            push.entry[2].smoothed_count    = m2;
            push.entry[2].bin_index         = sat_index(stage.seen);
            push.entry[2].last_result       = 1'b1;
         end
      end else if (tail_known || is_three || is_two) begin
         push.num                     = 2'd1;
         push.entry[0].smoothed_count = m0;
         push.entry[0].bin_index      = sat_index(stage.seen - SEEN_BITS'(2));
      end
      if (!stage_valid) begin
         push.num = 2'd0;
      end
   end

endmodule

// ===== hdl/hm5s_out_queue.sv =====
// ----------------------------------------------------------------------------
// hm5s_out_queue
// Small result queue that takes up to three results in one cycle and hands
// out one item per cycle on the result channel while rsp_stall is low.
// ----------------------------------------------------------------------------
module hm5s_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  hm5s_pkg::push_type  push,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hm5s_pkg::result_type rsp_item
);
   import hm5s_pkg::*;

   result_type [QUEUE_DEPTH-1:0] entry_ff, entry_in;
   logic [QPTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_BITS:0]   fill_ff, fill_in, fill_after_pop;
   logic                 pop;

   assign pop            = (fill_ff != '0) && !rsp_stall;
   assign fill_after_pop = fill_ff - {{QPTR_BITS{1'b0}}, pop};
   assign room           = (fill_after_pop <= (QPTR_BITS+1)'(QUEUE_DEPTH - MAX_RSP));

   always_comb begin
      entry_in = entry_ff;
      for (int i = 0; i < MAX_RSP; i++) begin
         if (2'(i) < push.num) begin
            entry_in[wr_ff + QPTR_BITS'(i)] = push.entry[i];
         end
      end
      wr_in   = wr_ff + QPTR_BITS'(push.num);
      rd_in   = rd_ff + {{(QPTR_BITS-1){1'b0}}, pop};
      fill_in = fill_after_pop + (QPTR_BITS+1)'(push.num);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      entry_ff <= entry_in;
   end

   assign rsp_valid = (fill_ff != '0);
   assign rsp_item  = entry_ff[rd_ff];

endmodule

// ===== hdl/histogram_median5_smoother.sv =====
// ----------------------------------------------------------------------------
// histogram_median5_smoother
// Five-bin median smoothing of a histogram stream with mirrored ends.
// ----------------------------------------------------------------------------
// Bins enter on the req_ channel in order, one item per bin, with
// req_last_bin set on the final bin. Each bin from the third on releases
// the median for the bin two places back; the final bin releases the last
// three medians, the last of them with rsp_last_result set. A histogram of
// fewer than five bins ends with one item that has rsp_short_run set and
// a zero count. Results leave on the rsp_ channel one item per cycle while
// rsp_stall is low. An accepted bin is registered in the stage and its
// results in the output queue. The block takes one bin per cycle while the
// receiver keeps up; a final bin's three results fill the four-entry queue
// and later bins wait. The sorting networks of one item sit between the
// stage register and that queue. Reset empties the queue and the stage and
// clears the bin history and count. When the receiver stalls, the queue
// fills and then req_stall rises until there is room for three results.
// ----------------------------------------------------------------------------
module histogram_median5_smoother (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [hm5s_pkg::COUNT_BITS-1:0]        req_bin_count,
   input  logic                                   req_last_bin,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [hm5s_pkg::COUNT_BITS-1:0]        rsp_smoothed_count,
   output logic [hm5s_pkg::INDEX_BITS-1:0]        rsp_bin_index,
   output logic                                   rsp_last_result,
   output logic                                   rsp_short_run
);
   import hm5s_pkg::*;

   logic       stage_valid;
   stage_type  stage;
   push_type   push;
   logic       room;
   logic       advance;
   logic       accept;
   result_type rsp_item;

   assign advance   = stage_valid && room;
   assign req_stall = stage_valid && !room;
   assign accept    = req_valid && !req_stall;

   hm5s_window u_window (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .bin_count   (req_bin_count),
      .last_bin    (req_last_bin),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   hm5s_median u_median (
      .stage_valid (advance),
      .stage       (stage),
      .push        (push)
   );

   hm5s_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_smoothed_count = rsp_item.smoothed_count;
   assign rsp_bin_index      = rsp_item.bin_index;
   assign rsp_last_result    = rsp_item.last_result;
   assign rsp_short_run      = rsp_item.short_run;

endmodule

// ===== sim/histogram_median5_smoother_tb.sv =====
// ----------------------------------------------------------------------------
// histogram_median5_smoother_tb
// Self-checking testbench for the five-bin histogram median smoother.
// ----------------------------------------------------------------------------
// Histograms of many lengths are streamed into the block. The bench keeps
// its own model of the mirrored median window and compares every result
// with it. Both sides idle at random, and the receiver also holds off long
// enough to back the block up into its input. The runs include short
// histograms, the mirrored ends, and a histogram long enough to saturate
// the bin index.
// ----------------------------------------------------------------------------
module histogram_median5_smoother_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hm5s_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int INDEX_LIMIT = (MAX_BINS - 1 < 255) ? MAX_BINS - 1 : 255;
   localparam int BINS_SEEN_CAP = 511;
   localparam count_type COUNT_MAX = '1;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [COUNT_BITS-1:0]  req_bin_count;
   logic                   req_last_bin;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [COUNT_BITS-1:0]  rsp_smoothed_count;
   logic [INDEX_BITS-1:0]  rsp_bin_index;
   logic                   rsp_last_result;
   logic                   rsp_short_run;

   count_type              window_bins [HIST_DEPTH];
   int                     bins_in_histogram;
   result_type             pending_medians [$];
   int                     error_count;
   int                     cycle_count;
   int                     receiver_hold;
   bit                     steady;

   histogram_median5_smoother dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_bin_count      (req_bin_count),
      .req_last_bin       (req_last_bin),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_smoothed_count (rsp_smoothed_count),
      .rsp_bin_index      (rsp_bin_index),
      .rsp_last_result    (rsp_last_result),
      .rsp_short_run      (rsp_short_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic count_type median_of(count_type a, count_type b, count_type c,
                                           count_type d, count_type e);
      count_type vals [5];
      int below;
      int at_or_below;
      vals = '{a, b, c, d, e};
      for (int i = 0; i < 5; i++) begin
         below = 0;
         at_or_below = 0;
         for (int k = 0; k < 5; k++) begin
            if (vals[k] < vals[i]) below++;
            if (vals[k] <= vals[i]) at_or_below++;
         end
         if (below <= 2 && at_or_below >= 3) return vals[i];
      end
      return '0;
   endfunction

   function automatic void queue_median(count_type value, int index, bit final_bin,
                                        bit short_hist);
      result_type r;
      r.smoothed_count = value;
      r.bin_index      = INDEX_BITS'((index > INDEX_LIMIT) ? INDEX_LIMIT : index);
      r.last_result    = final_bin;
      r.short_run      = short_hist;
      pending_medians.push_back(r);
   endfunction

   function automatic void smooth_bin(count_type c, logic last);
      count_type h0, h1, h2, h3;
      int j;
      h0 = window_bins[0];
      h1 = window_bins[1];
      h2 = window_bins[2];
      h3 = window_bins[3];
      j  = bins_in_histogram;
      if (last) begin
         if (j < 4) begin
            queue_median('0, 0, 1'b1, 1'b1);
         end else begin
            queue_median(median_of(h3, h2, h1, h0, c), j - 2, 1'b0, 1'b0);
            queue_median(median_of(h2, h1, h0, c, h0), j - 1, 1'b0, 1'b0);
            queue_median(median_of(h1, h0, c, h0, h1), j, 1'b1, 1'b0);
         end
         window_bins = '{default: '0};
         bins_in_histogram = 0;
      end else begin
         if (j >= 4) queue_median(median_of(h3, h2, h1, h0, c), j - 2, 1'b0, 1'b0);
         else if (j == 3) queue_median(median_of(h1, h2, h1, h0, c), 1, 1'b0, 1'b0);
         else if (j == 2) queue_median(median_of(c, h0, h1, h0, c), 0, 1'b0, 1'b0);
         window_bins[3] = h2;
         window_bins[2] = h1;
         window_bins[1] = h0;
         window_bins[0] = c;
         if (bins_in_histogram < BINS_SEEN_CAP) bins_in_histogram++;
      end
   endfunction

   function automatic count_type random_count();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return COUNT_MAX;
         2, 3, 4: return count_type'($urandom_range(0, 7));
         default: return count_type'($urandom);
      endcase
   endfunction

   task automatic send_bin(input count_type count, input logic last);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_bin_count = count;
      req_last_bin  = last;
      do @(posedge clock); while (req_stall);
      smooth_bin(count, last);
   endtask

   task automatic send_histogram(input int length);
      for (int i = 0; i < length; i++) send_bin(random_count(), i == length - 1);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
   endtask

   task automatic test_short_histograms();
      send_bin('0, 1'b1);
      send_bin(COUNT_MAX, 1'b0);
      send_bin('0, 1'b1);
      send_bin(20'd5, 1'b0);
      send_bin(COUNT_MAX, 1'b0);
      send_bin(20'd1, 1'b1);
      send_bin(COUNT_MAX, 1'b0);
      send_bin('0, 1'b0);
      send_bin(20'd9, 1'b0);
      send_bin(20'd3, 1'b1);
   endtask

   task automatic test_mirrored_ends();
      send_bin(20'd10, 1'b0);
      send_bin(20'd50, 1'b0);
      send_bin(20'd20, 1'b0);
      send_bin(COUNT_MAX, 1'b0);
      send_bin('0, 1'b1);
      send_bin(20'd7, 1'b0);
      send_bin(20'd3, 1'b0);
      send_bin(20'd9, 1'b0);
      send_bin(20'd1, 1'b0);
      send_bin(COUNT_MAX, 1'b0);
      send_bin(20'd5, 1'b1);
   endtask

   task automatic test_random_histograms();
      int sent;
      int length;
      sent = 0;
      while (sent < 12) begin
         steady = ($urandom_range(0, 4) == 0);
         length = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5)
                                              : $urandom_range(1, 16);
         send_histogram(length);
         sent += length;
      end
      steady = 1'b0;
   endtask

   task automatic test_backpressure();
      receiver_hold = 60;
      steady = 1'b1;
      send_histogram(20);
      steady = 1'b0;
      wait_drained();
      send_histogram(6);
   endtask

   task automatic test_long_histogram();
      send_histogram(258);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_bin_count = '0;
      req_last_bin  = 1'b0;
      rsp_stall     = 1'b0;
      window_bins   = '{default: '0};
      bins_in_histogram = 0;
      error_count   = 0;
      receiver_hold = 0;
      steady        = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_short_histograms();
      test_mirrored_ends();
      test_random_histograms();
      test_backpressure();
      test_long_histogram();

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_medians.size() == 0) begin
         $display("histogram_median5_smoother_tb: done, clean");
      end else begin
         $display("histogram_median5_smoother_tb: done, errors");
      end
      $finish;
   end

   initial begin
      int wait_cycles;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (receiver_hold > 0) begin
            wait_cycles = receiver_hold;
            receiver_hold = 0;
         end else begin
            wait_cycles = steady ? 0 : $urandom_range(0, 5);
         end
         if (wait_cycles > 0) begin
            rsp_stall = 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_medians.size() == 0) begin
            $error("unexpected result: count %0d, index %0d", rsp_smoothed_count,
                   rsp_bin_index);
            error_count++;
         end else begin
            want = pending_medians.pop_front();
            if (rsp_smoothed_count !== want.smoothed_count) begin
               $error("rsp_smoothed_count: expected %0d, got %0d", want.smoothed_count,
                      rsp_smoothed_count);
               error_count++;
            end
            if (rsp_bin_index !== want.bin_index) begin
               $error("rsp_bin_index: expected %0d, got %0d", want.bin_index,
                      rsp_bin_index);
               error_count++;
            end
            if (rsp_last_result !== want.last_result) begin
               $error("rsp_last_result: expected %0b, got %0b", want.last_result,
                      rsp_last_result);
               error_count++;
            end
            if (rsp_short_run !== want.short_run) begin
               $error("rsp_short_run: expected %0b, got %0b", want.short_run,
                      rsp_short_run);
               error_count++;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("histogram_median5_smoother_tb: done, errors");
            $finish;
         end
      end
   end

endmodule
